// ===== design/ordered_pid_translation_table_core_assert.svh =====
// Assertion macros used by the checker of the ordered PID translation table.
// Depends on a clock named clk and an active-low reset named rst_n in the scope of use.
`ifndef ORDERED_PID_TRANSLATION_TABLE_CORE_ASSERT_SVH
`define ORDERED_PID_TRANSLATION_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/opt_pkg.sv =====
// Package of the ordered PID translation table: operation and status codes, cell control type.
// No dependencies; every other design file but the assertion header imports it.
package opt_pkg;

  localparam int OP_W = 2;
  localparam int ST_W = 2;

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Control part of the request token that walks along the cell row.
  typedef struct packed {
    logic vld;
    op_t  op;
    logic hit;
  } tok_ctl_t;

endpackage

// ===== design/opt_if.sv =====
// Valid/ready channel interfaces for the request and result sides of the table.
// Depends on opt_pkg for the field widths of the codes.
interface opt_req_if import opt_pkg::*; #(
  parameter int KEY_BITS   = 16,
  parameter int INDEX_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [KEY_BITS-1:0]   pid;
  logic [INDEX_BITS-1:0] mem_ref;

  modport source (output valid, op, pid, mem_ref, input ready);
  modport sink   (input valid, op, pid, mem_ref, output ready);
endinterface

interface opt_rsp_if import opt_pkg::*; #(
  parameter int INDEX_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [ST_W-1:0]       status;
  logic [INDEX_BITS-1:0] found_index;

  modport source (output valid, status, found_index, input ready);
  modport sink   (input valid, status, found_index, output ready);
endinterface

// ===== design/ordered_pid_translation_table_core.sv =====
// A request transfer injects a token into the first slot cell; its result passes through
// the pending and output registers once the token leaves the last cell. The token walks the
// row of slot cells one cell per cycle, and only one request is in the row at a time.
// A new request is taken while the previous result still waits on the output.
// Reset (synchronous, active low) empties the table by clearing the fill count and
// drops any request in flight; slot contents are not cleared and need no clearing pass.
module ordered_pid_translation_table_core import opt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 16,
  parameter int INDEX_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  opt_req_if.sink    in_ch,
  opt_rsp_if.source  out_ch
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  tok_ctl_t              ctl_q   [TABLE_DEPTH];
  logic [KEY_BITS-1:0]   pid_q   [TABLE_DEPTH];
  logic [INDEX_BITS-1:0] data_q  [TABLE_DEPTH];
  logic                  shift_q [TABLE_DEPTH];
  logic [KEY_BITS-1:0]   key_q   [TABLE_DEPTH];
  logic [INDEX_BITS-1:0] val_q   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] occ;

  tok_ctl_t              head_ctl;
  tok_ctl_t              last_ctl;
  logic                  accept;
  logic                  done;
  logic                  move;
  status_t               fin_status;
  logic [INDEX_BITS-1:0] fin_idx;

  logic [CNT_W-1:0]      fill_count_r, fill_count_nxt;
  logic                  busy_r, busy_nxt;
  logic                  pend_r, pend_nxt;
  status_t               pend_status_r;
  logic [INDEX_BITS-1:0] pend_idx_r;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r;
  logic [INDEX_BITS-1:0] out_idx_r;

  // Request transfer injects a token into the first cell.
  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;

  always_comb begin
    head_ctl     = '0;
    head_ctl.vld = accept;
    head_ctl.op  = op_t'(in_ch.op);
    head_ctl.hit = 1'b0;
  end

  // Slot row: each cell sees its occupancy and passes the token to the right.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign occ[i] = fill_count_r > CNT_W'(i);

    if (i == 0) begin : g_first
      opt_cell #(.KEY_BITS(KEY_BITS), .INDEX_BITS(INDEX_BITS)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .occ       (occ[i]),
        .ctl_in    (head_ctl),
        .pid_in    (in_ch.pid),
        .data_in   (in_ch.mem_ref),
        .ctl_out   (ctl_q[i]),
        .pid_out   (pid_q[i]),
        .data_out  (data_q[i]),
        .shift_in  (shift_q[i+1]),
        .nbr_key   (key_q[i+1]),
        .nbr_val   (val_q[i+1]),
        .shift_out (shift_q[i]),
        .key_out   (key_q[i]),
        .val_out   (val_q[i])
      );
    end else if (i == TABLE_DEPTH - 1) begin : g_last
      opt_cell #(.KEY_BITS(KEY_BITS), .INDEX_BITS(INDEX_BITS)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .occ       (occ[i]),
        .ctl_in    (ctl_q[i-1]),
        .pid_in    (pid_q[i-1]),
        .data_in   (data_q[i-1]),
        .ctl_out   (ctl_q[i]),
        .pid_out   (pid_q[i]),
        .data_out  (data_q[i]),
        .shift_in  (1'b0),
        .nbr_key   ({KEY_BITS{1'b0}}),
        .nbr_val   ({INDEX_BITS{1'b0}}),
        .shift_out (shift_q[i]),
        .key_out   (key_q[i]),
        .val_out   (val_q[i])
      );
    end else begin : g_mid
      opt_cell #(.KEY_BITS(KEY_BITS), .INDEX_BITS(INDEX_BITS)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .occ       (occ[i]),
        .ctl_in    (ctl_q[i-1]),
        .pid_in    (pid_q[i-1]),
        .data_in   (data_q[i-1]),
        .ctl_out   (ctl_q[i]),
        .pid_out   (pid_q[i]),
        .data_out  (data_q[i]),
        .shift_in  (shift_q[i+1]),
        .nbr_key   (key_q[i+1]),
        .nbr_val   (val_q[i+1]),
        .shift_out (shift_q[i]),
        .key_out   (key_q[i]),
        .val_out   (val_q[i])
      );
    end
  end

  // Result of the token leaving the last cell.
  assign last_ctl = ctl_q[TABLE_DEPTH-1];
  assign done     = last_ctl.vld;

  always_comb begin
    fin_status = ST_MISS;
    fin_idx    = '0;
    case (last_ctl.op)
      OP_INSERT: begin
        fin_status = last_ctl.hit ? ST_OK : ST_FULL;
      end
      OP_REMOVE, OP_FIND: begin
        if (last_ctl.hit) begin
          fin_status = ST_OK;
          fin_idx    = data_q[TABLE_DEPTH-1];
        end
      end
      default: begin
        fin_status = ST_MISS;
      end
    endcase
  end

  // Fill count follows a successful insert or remove once the token has finished.
  always_comb begin
    fill_count_nxt = fill_count_r;
    if (done && last_ctl.hit) begin
      if (last_ctl.op == OP_INSERT) begin
        fill_count_nxt = fill_count_r + CNT_W'(1);
      end else if (last_ctl.op == OP_REMOVE) begin
        fill_count_nxt = fill_count_r - CNT_W'(1);
      end
    end
  end

  // The pending result moves to the output register once that register is free.
  assign move = pend_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (move) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (done) begin
      pend_nxt = 1'b1;
    end else if (move) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      busy_r       <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_count_r <= fill_count_nxt;
      busy_r       <= busy_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (done) begin
      pend_status_r <= fin_status;
      pend_idx_r    <= fin_idx;
    end
    if (move) begin
      out_status_r <= pend_status_r;
      out_idx_r    <= pend_idx_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_idx_r;

endmodule

// ===== design/opt_cell.sv =====
// One slot of the table: holds a key/index pair and processes the passing request token.
// Depends on opt_pkg for the token control type and operation codes.
module opt_cell import opt_pkg::*; #(
  parameter int KEY_BITS   = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  occ,
  input  tok_ctl_t              ctl_in,
  input  logic [KEY_BITS-1:0]   pid_in,
  input  logic [INDEX_BITS-1:0] data_in,
  output tok_ctl_t              ctl_out,
  output logic [KEY_BITS-1:0]   pid_out,
  output logic [INDEX_BITS-1:0] data_out,
  input  logic                  shift_in,
  input  logic [KEY_BITS-1:0]   nbr_key,
  input  logic [INDEX_BITS-1:0] nbr_val,
  output logic                  shift_out,
  output logic [KEY_BITS-1:0]   key_out,
  output logic [INDEX_BITS-1:0] val_out
);

  tok_ctl_t              ctl_r, ctl_nxt;
  logic [KEY_BITS-1:0]   pid_r;
  logic [INDEX_BITS-1:0] data_r, data_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [INDEX_BITS-1:0] val_r, val_nxt;
  logic                  match;
  logic                  wr_ins;

  assign match = occ && (key_r == pid_in);

  // Token processing: the first free slot takes an insert, the first matching slot a lookup.
  always_comb begin
    ctl_nxt  = ctl_in;
    data_nxt = data_in;
    wr_ins   = 1'b0;
    if (ctl_in.vld && !ctl_in.hit) begin
      case (ctl_in.op)
        OP_INSERT: begin
          if (!occ) begin
            ctl_nxt.hit = 1'b1;
            wr_ins      = 1'b1;
          end
        end
        OP_REMOVE, OP_FIND: begin
          if (match) begin
            ctl_nxt.hit = 1'b1;
            data_nxt    = val_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A remove that already hit upstream pulls this slot one place toward the head.
  assign shift_out = ctl_in.vld && (ctl_in.op == OP_REMOVE) && ctl_in.hit && occ;

  // Slot contents: written by an insert or by the compaction from the right neighbor.
  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    if (wr_ins) begin
      key_nxt = pid_in;
      val_nxt = data_in;
    end else if (shift_in) begin
      key_nxt = nbr_key;
      val_nxt = nbr_val;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    pid_r  <= pid_in;
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  assign ctl_out  = ctl_r;
  assign pid_out  = pid_r;
  assign data_out = data_r;
  assign key_out  = key_r;
  assign val_out  = val_r;

endmodule

// ===== design/opt_checker.sv =====
// Port-level checker for the ordered PID translation table, with its bind to the top level.
// Depends on opt_pkg and the assertion macros in ordered_pid_translation_table_core_assert.svh.
`include "ordered_pid_translation_table_core_assert.svh"

module opt_checker import opt_pkg::*; #(
  parameter int INDEX_BITS = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [ST_W-1:0]       out_status,
  input logic [INDEX_BITS-1:0] out_found_index
);

  logic status_legal;

  // The status carries one of the defined codes.
  assign status_legal = (out_status == ST_OK) || (out_status == ST_MISS) ||
                        (out_status == ST_FULL);

  // Only one request is in the table at a time.
  `OPT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second request taken while busy")

  // Only defined status codes are produced.
  `OPT_ASSERT_SAME(a_status_legal, out_valid, status_legal, "illegal status code")

  // Any status but OK carries a zero index.
  `OPT_ASSERT_SAME(a_miss_zero, out_valid && (out_status != ST_OK), out_found_index == '0, "nonzero index without a hit")

  // A stalled result holds its payload.
  `OPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_found_index), "stalled result changed")

endmodule

bind ordered_pid_translation_table_core opt_checker #(.INDEX_BITS(INDEX_BITS)) u_opt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found_index (out_ch.found_index)
);

// ===== test/tb_ordered_pid_translation_table_core.sv =====
`timescale 1ns / 1ps
// Testbench of ordered_pid_translation_table_core: checks insert, remove and find
// results against an in-bench table model. Depends on opt_pkg, opt_if.sv and the core.
module tb_ordered_pid_translation_table_core;
  import opt_pkg::*;

  localparam int TABLE_DEPTH     = 16;
  localparam int KEY_BITS        = 16;
  localparam int INDEX_BITS      = 16;
  localparam int RANDOM_ITEMS    = 550;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 2 * (TABLE_DEPTH + 3);
  localparam int REPORT_LIMIT    = 10;

  // One expected result of the table.
  typedef struct packed {
    status_t               status;
    logic [INDEX_BITS-1:0] found_index;
  } reply_t;

  // Ordered table of (pid, memory index) pairs and the replies still owed by the core.
  class pid_table_model;
    logic [KEY_BITS-1:0]   slot_pid[$];
    logic [INDEX_BITS-1:0] slot_index[$];
    reply_t                pending[$];
    int unsigned           mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: mismatch: %s", $time, msg);
      end
    endfunction

    // Apply one accepted request to the table and queue the reply it owes.
    function void note_request(op_t op, logic [KEY_BITS-1:0] pid,
                               logic [INDEX_BITS-1:0] idx);
      reply_t r;
      int     pos;
      int     i;
      r.status      = ST_MISS;
      r.found_index = '0;
      pos = -1;
      for (i = 0; i < slot_pid.size() && pos < 0; i++) begin
        if (slot_pid[i] == pid) pos = i;
      end
      case (op)
        OP_INSERT: begin
          if (slot_pid.size() < TABLE_DEPTH) begin
            slot_pid.push_back(pid);
            slot_index.push_back(idx);
            r.status = ST_OK;
          end else begin
            r.status = ST_FULL;
          end
        end
        OP_REMOVE: begin
          if (pos >= 0) begin
            r.status      = ST_OK;
            r.found_index = slot_index[pos];
            slot_pid.delete(pos);
            slot_index.delete(pos);
          end
        end
        OP_FIND: begin
          if (pos >= 0) begin
            r.status      = ST_OK;
            r.found_index = slot_index[pos];
          end
        end
        default: begin
        end
      endcase
      pending.push_back(r);
    endfunction

    // Compare one result transfer with the oldest reply owed.
    function void check_reply(logic [ST_W-1:0] status, logic [INDEX_BITS-1:0] idx);
      reply_t r;
      if (pending.size() == 0) begin
        flag($sformatf("result status=%0d index=%h with no request pending", status, idx));
        return;
      end
      r = pending.pop_front();
      if (status !== r.status) begin
        flag($sformatf("status expected %0d, got %0d", r.status, status));
      end
      if (idx !== r.found_index) begin
        flag($sformatf("found_index expected %h, got %h", r.found_index, idx));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  opt_req_if #(.KEY_BITS(KEY_BITS), .INDEX_BITS(INDEX_BITS)) req_ch ();
  opt_rsp_if #(.INDEX_BITS(INDEX_BITS)) rsp_ch ();

  ordered_pid_translation_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch.sink),
    .out_ch(rsp_ch.source)
  );

  pid_table_model table_model = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_armed;
  int unsigned quiet_cycles;

  // Free-running clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Record request transfers and check result transfers at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        table_model.check_reply(rsp_ch.status, rsp_ch.found_index);
      end
      if (req_ch.valid && req_ch.ready) begin
        table_model.note_request(op_t'(req_ch.op), req_ch.pid, req_ch.mem_ref);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[ordered_pid_translation_table_core] ERROR");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold once armed.
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one request, with random idle cycles first, and wait for its transfer.
  task automatic send_request(input op_t op, input logic [KEY_BITS-1:0] pid,
                              input logic [INDEX_BITS-1:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid   = 1'b1;
    req_ch.op      = op;
    req_ch.pid     = pid;
    req_ch.mem_ref = idx;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Bursts that lean to filling, draining or a mix, with keys mostly from a small pool
  // so that lookups hit and duplicates occur.
  task automatic run_random(input int unsigned count);
    logic [KEY_BITS-1:0]   key_pool[8];
    logic [KEY_BITS-1:0]   pid;
    logic [INDEX_BITS-1:0] idx;
    op_t                   op;
    int unsigned           n;
    int unsigned           burst;
    int unsigned           mode;
    int unsigned           roll;
    int unsigned           b;
    int unsigned           k;
    for (k = 0; k < 8; k++) key_pool[k] = KEY_BITS'($urandom);
    key_pool[0] = '0;
    key_pool[7] = '1;
    n = 0;
    while (n < count) begin
      mode  = $urandom_range(2);
      burst = $urandom_range(8, 40);
      key_pool[$urandom_range(1, 6)] = KEY_BITS'($urandom);
      for (b = 0; b < burst && n < count; b++) begin
        roll = $urandom_range(99);
        case (mode)
          0:       op = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_REMOVE :
                        (roll < 95) ? OP_FIND : OP_NONE;
          1:       op = (roll < 15) ? OP_INSERT : (roll < 70) ? OP_REMOVE :
                        (roll < 95) ? OP_FIND : OP_NONE;
          default: op = (roll < 40) ? OP_INSERT : (roll < 65) ? OP_REMOVE :
                        (roll < 95) ? OP_FIND : OP_NONE;
        endcase
        if ($urandom_range(99) < 85) pid = key_pool[$urandom_range(7)];
        else pid = KEY_BITS'($urandom);
        roll = $urandom_range(99);
        if (roll < 5) idx = '0;
        else if (roll < 10) idx = '1;
        else idx = INDEX_BITS'($urandom);
        send_request(op, pid, idx);
        n++;
      end
    end
  endtask

  // Main sequence: reset, directed cases, then three random phases.
  initial begin : stimulus
    int i;
    req_ch.valid   = 1'b0;
    req_ch.op      = OP_NONE;
    req_ch.pid     = '0;
    req_ch.mem_ref = '0;
    tx_idle_pct    = 25;
    rx_idle_pct    = 69;
    hold_armed     = 1'b0;
    rst_n          = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Lookups and the unused code on an empty table.
    send_request(OP_FIND, 16'h1234, 16'h0000);
    send_request(OP_REMOVE, 16'h0000, 16'hffff);
    send_request(OP_NONE, 16'hffff, 16'hffff);
    // Fill the table with repeated keys and extreme indexes, then overflow it.
    for (i = 0; i < TABLE_DEPTH; i++) begin
      send_request(OP_INSERT,
                   (i % 4 == 0) ? 16'h0000 : (i % 4 == 3) ? 16'hffff : 16'h5a00 + 16'(i),
                   16'(i * 16'h1111));
    end
    send_request(OP_INSERT, 16'hffff, 16'hffff);
    // Remove from the middle so younger entries close the gap.
    send_request(OP_REMOVE, 16'h5a05, 16'h0000);
    // A duplicated key always resolves to its oldest entry.
    send_request(OP_FIND, 16'h0000, 16'hffff);
    send_request(OP_REMOVE, 16'h0000, 16'h0000);
    send_request(OP_FIND, 16'h0000, 16'h0000);
    send_request(OP_FIND, 16'h5a05, 16'h0000);

    run_random(RANDOM_ITEMS / 3);
    tx_idle_pct = 69;
    rx_idle_pct = 25;
    run_random(RANDOM_ITEMS / 3);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_armed  = 1'b1;
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (table_model.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_model.mismatches == 0) begin
      $display("[ordered_pid_translation_table_core] OK");
    end else begin
      $display("[ordered_pid_translation_table_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== ordered_pid_translation_table_core.f =====
+incdir+design
design/opt_pkg.sv
design/opt_if.sv
design/opt_cell.sv
design/ordered_pid_translation_table_core.sv
design/opt_checker.sv
test/tb_ordered_pid_translation_table_core.sv
